[src/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipping cycles in reset.
`define LAGE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LAGE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lage_pkg.sv]
package lage_pkg;

    // Board limits
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int MIN_DIM  = 3;
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int ROW_AW   = $clog2(MAX_ROWS);

    // Register widths
    localparam int DIM_W      = 7;
    localparam int GEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;

    // One sweep: MAX_ROWS reads, then the row window drains
    localparam int SWEEP_W = $clog2(MAX_ROWS + 2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_COUNT    = 2'd2;

    typedef enum logic [S_USER_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

[src/lage_ram.sv]
module lage_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/life_automaton_generation_engine.sv]
// Channel   Direction  Ports                                Word
// s_        in         s_tvalid s_tready s_tdata s_tuser    one command (write, run, read)
// m_        out        m_tvalid m_tready m_tdata            one status word per command
// cfg_      in         cfg_we cfg_index cfg_wdata           board size, generation count
//
// Write and read commands stream back to back while the m_ side keeps up: a command
// is accepted while the previous one does its read-modify-write on the row memories.
// A run command steps through generation_count generations, then reports; each
// generation sweeps every row of the current store through one read port.
// Reset clears control state and the per-row valid bits: rows never written read dead.
// A stalled m_ side holds one finished word and one word in flight, then drops s_tready.
module life_automaton_generation_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: col_index[5:0], row_index[11:6], cell_value[12], zero pad
    // s_tuser: op[1:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lage_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [lage_pkg::S_USER_W-1:0]       s_tuser,
    // m_tdata: cell_out[0], finished[1], out_of_range[2], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lage_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [lage_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lage_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import lage_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [GEN_W-1:0] gen_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DIM_W'(MAX_COLS);
            height_reg    <= DIM_W'(MAX_ROWS);
            gen_count_reg <= GEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BOARD_WIDTH:  width_reg     <= cfg_wdata[DIM_W-1:0];
                REG_BOARD_HEIGHT: height_reg    <= cfg_wdata[DIM_W-1:0];
                REG_GEN_COUNT:    gen_count_reg <= cfg_wdata[GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the board size into its usable range
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_comb begin
        w_eff = width_reg;
        if (width_reg < DIM_W'(MIN_DIM)) begin
            w_eff = DIM_W'(MIN_DIM);
        end else if (width_reg > DIM_W'(MAX_COLS)) begin
            w_eff = DIM_W'(MAX_COLS);
        end
        h_eff = height_reg;
        if (height_reg < DIM_W'(MIN_DIM)) begin
            h_eff = DIM_W'(MIN_DIM);
        end else if (height_reg > DIM_W'(MAX_ROWS)) begin
            h_eff = DIM_W'(MAX_ROWS);
        end
    end

    // ------------------------------------------------------------------
    // Input word decode
    // ------------------------------------------------------------------
    op_t               in_op;
    logic [COL_AW-1:0] in_col;
    logic [ROW_AW-1:0] in_row;
    logic              in_val;
    logic              in_off_board;
    logic              s_fire;

    assign in_op        = op_t'(s_tuser);
    assign in_col       = s_tdata[COL_AW-1:0];
    assign in_row       = s_tdata[COL_AW +: ROW_AW];
    assign in_val       = s_tdata[COL_AW + ROW_AW];
    assign in_off_board = (DIM_W'(in_col) >= w_eff) || (DIM_W'(in_row) >= h_eff);
    assign s_fire       = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t             state_reg;
    state_t             state_next;
    logic [SWEEP_W-1:0] sweep_reg;
    logic [GEN_W-1:0]   gen_left_reg;
    logic               cur_is_b_reg;
    logic               s1_valid_reg;
    logic               m_valid_reg;

    logic out_free;
    logic s1_adv;
    logic sweep_last;
    logic sweep_rd;
    logic sweep_shift;
    logic sweep_wr;
    logic fin_load;
    logic in_run;

    assign out_free   = !m_valid_reg || m_tready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign sweep_last = (sweep_reg == SWEEP_W'(MAX_ROWS + 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_op == OP_RUN) begin
                    state_next = (gen_count_reg == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                if (sweep_last && gen_left_reg == GEN_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready    = 1'b0;
        fin_load    = 1'b0;
        in_run      = 1'b0;
        sweep_rd    = 1'b0;
        sweep_shift = 1'b0;
        sweep_wr    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // Take a word only when stage 1 is empty or moves on this cycle
                s_tready = !s1_valid_reg || out_free;
            end
            ST_RUN: begin
                in_run      = 1'b1;
                sweep_rd    = (sweep_reg < SWEEP_W'(MAX_ROWS));
                sweep_shift = (sweep_reg != '0) && (sweep_reg <= SWEEP_W'(MAX_ROWS));
                sweep_wr    = (sweep_reg >= SWEEP_W'(2));
            end
            ST_FINISH: begin
                fin_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sweep_reg    <= '0;
            gen_left_reg <= '0;
            cur_is_b_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire && in_op == OP_RUN) begin
                sweep_reg    <= '0;
                gen_left_reg <= gen_count_reg;
            end else if (in_run) begin
                if (sweep_last) begin
                    // Generation done: the freshly written store becomes current
                    sweep_reg    <= '0;
                    gen_left_reg <= gen_left_reg - GEN_W'(1);
                    cur_is_b_reg <= !cur_is_b_reg;
                end else begin
                    sweep_reg <= sweep_reg + SWEEP_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Row memories: store A and store B, one row of cells per entry
    // ------------------------------------------------------------------
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic [MAX_COLS-1:0] rdata_a;
    logic [MAX_COLS-1:0] rdata_b;
    logic                we_a;
    logic                we_b;
    logic [ROW_AW-1:0]   waddr;
    logic [MAX_COLS-1:0] wdata_a;
    logic [MAX_COLS-1:0] wdata_b;

    lage_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata_a),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    lage_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata_b),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    // Per-row valid bits stand in for clearing the memories after reset
    logic [MAX_ROWS-1:0] vld_a_reg;
    logic [MAX_ROWS-1:0] vld_b_reg;
    logic                rd_vld_a_reg;
    logic                rd_vld_b_reg;

    assign rd_en   = s_fire || sweep_rd;
    assign rd_addr = in_run ? sweep_reg[ROW_AW-1:0] : in_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end else begin
            if (we_a) begin
                vld_a_reg[waddr] <= 1'b1;
            end
            if (we_b) begin
                vld_b_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_a_reg <= vld_a_reg[rd_addr];
            rd_vld_b_reg <= vld_b_reg[rd_addr];
        end
    end

    logic [MAX_COLS-1:0] clean_a;
    logic [MAX_COLS-1:0] clean_b;
    logic [MAX_COLS-1:0] cur_rd;

    assign clean_a = rd_vld_a_reg ? rdata_a : '0;
    assign clean_b = rd_vld_b_reg ? rdata_b : '0;
    assign cur_rd  = cur_is_b_reg ? clean_b : clean_a;

    // ------------------------------------------------------------------
    // Stage 1: cell write and cell read against the registered row
    // ------------------------------------------------------------------
    op_t               s1_op_reg;
    logic [COL_AW-1:0] s1_col_reg;
    logic [ROW_AW-1:0] s1_row_reg;
    logic              s1_val_reg;
    logic              s1_off_reg;
    logic              s1_hit_reg;
    logic [COL_AW-1:0] s1_hit_col_reg;
    logic              s1_hit_val_reg;
    logic              s1_wr;

    assign s1_wr = s1_adv && (s1_op_reg == OP_WRITE) && !s1_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire && in_op != OP_RUN) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg      <= in_op;
            s1_col_reg     <= in_col;
            s1_row_reg     <= in_row;
            s1_val_reg     <= in_val;
            s1_off_reg     <= (in_op == OP_WRITE || in_op == OP_READ) && in_off_board;
            // A write leaving stage 1 this cycle lands after our read: patch it in
            s1_hit_reg     <= s1_wr && (s1_row_reg == in_row);
            s1_hit_col_reg <= s1_col_reg;
            s1_hit_val_reg <= s1_val_reg;
        end
    end

    logic [MAX_COLS-1:0] word_a;
    logic [MAX_COLS-1:0] word_b;
    logic [MAX_COLS-1:0] new_a;
    logic [MAX_COLS-1:0] new_b;
    logic [MAX_COLS-1:0] cur_word;

    always_comb begin
        word_a = clean_a;
        word_b = clean_b;
        if (s1_hit_reg) begin
            word_a[s1_hit_col_reg] = s1_hit_val_reg;
            word_b[s1_hit_col_reg] = s1_hit_val_reg;
        end
        new_a             = word_a;
        new_b             = word_b;
        new_a[s1_col_reg] = s1_val_reg;
        new_b[s1_col_reg] = s1_val_reg;
        cur_word          = cur_is_b_reg ? word_b : word_a;
    end

    logic s1_cell;
    logic s1_fin;
    logic s1_off;

    always_comb begin
        s1_cell = 1'b0;
        s1_fin  = 1'b0;
        s1_off  = 1'b0;
        unique case (s1_op_reg)
            OP_WRITE: begin
                s1_fin = !s1_off_reg;
                s1_off = s1_off_reg;
            end
            OP_READ: begin
                s1_cell = !s1_off_reg && cur_word[s1_col_reg];
                s1_fin  = !s1_off_reg;
                s1_off  = s1_off_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Generation sweep: a three-row window slides down the current store
    // ------------------------------------------------------------------
    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] mid_reg;

    always_ff @(posedge aclk) begin
        if (sweep_shift) begin
            up_reg  <= mid_reg;
            mid_reg <= cur_rd;
        end
    end

    // Row being produced lags the read address by two
    logic [ROW_AW-1:0]   gen_row_idx;
    logic                gen_interior;
    logic [MAX_COLS-1:0] inner;
    logic [MAX_COLS-1:0] life;
    logic [MAX_COLS-1:0] gen_row;

    assign gen_row_idx  = ROW_AW'(sweep_reg - SWEEP_W'(2));
    assign gen_interior = (gen_row_idx != '0) &&
                          ((DIM_W'(gen_row_idx) + DIM_W'(1)) < h_eff);

    always_comb begin
        logic [MAX_COLS-1:0] up_l;
        logic [MAX_COLS-1:0] up_r;
        logic [MAX_COLS-1:0] mid_l;
        logic [MAX_COLS-1:0] mid_r;
        logic [MAX_COLS-1:0] dn_l;
        logic [MAX_COLS-1:0] dn_r;
        logic [3:0]          cnt;
        up_l  = up_reg << 1;
        up_r  = up_reg >> 1;
        mid_l = mid_reg << 1;
        mid_r = mid_reg >> 1;
        dn_l  = cur_rd << 1;
        dn_r  = cur_rd >> 1;
        for (int c = 0; c < MAX_COLS; c++) begin
            cnt = 4'(up_l[c]) + 4'(up_reg[c]) + 4'(up_r[c]) + 4'(mid_l[c]) +
                  4'(mid_r[c]) + 4'(dn_l[c]) + 4'(cur_rd[c]) + 4'(dn_r[c]);
            life[c]  = (cnt == 4'd3) || ((cnt == 4'd2) && mid_reg[c]);
            inner[c] = (c != 0) && ((DIM_W'(c) + DIM_W'(1)) < w_eff);
        end
        gen_row = gen_interior ? ((mid_reg & ~inner) | (life & inner)) : mid_reg;
    end

    // Write port: the sweep owns it during a run, stage 1 otherwise
    always_comb begin
        if (in_run) begin
            we_a    = sweep_wr && cur_is_b_reg;
            we_b    = sweep_wr && !cur_is_b_reg;
            waddr   = gen_row_idx;
            wdata_a = gen_row;
            wdata_b = gen_row;
        end else begin
            we_a    = s1_wr;
            we_b    = s1_wr;
            waddr   = s1_row_reg;
            wdata_a = new_a;
            wdata_b = new_b;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic m_cell_reg;
    logic m_fin_reg;
    logic m_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv || fin_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_cell_reg <= s1_cell;
            m_fin_reg  <= s1_fin;
            m_off_reg  <= s1_off;
        end else if (fin_load) begin
            m_cell_reg <= 1'b0;
            m_fin_reg  <= 1'b1;
            m_off_reg  <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 3){1'b0}}, m_off_reg, m_fin_reg, m_cell_reg};

endmodule

[src/lage_checker.sv]
module lage_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lage_pkg::S_USER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lage_pkg::M_DATA_W-1:0]   m_tdata
);

    import lage_pkg::*;

    `include "assert_macros.svh"

    // Hold a stalled result word
    `LAGE_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // An off-board command never reports completion
    `LAGE_ASSERT(a_off_not_fin, aclk, aresetn, m_tvalid |-> !(m_tdata[1] && m_tdata[2]), "finished and out_of_range both set")

    // A live cell only comes back from a completed read
    `LAGE_ASSERT(a_cell_fin, aclk, aresetn, m_tvalid && m_tdata[0] |-> m_tdata[1] && !m_tdata[2], "cell_out set without a completed read")

    // Drop s_tready right after a run word is taken
    `LAGE_ASSERT(a_run_blocks, aclk, aresetn, s_tvalid && s_tready && s_tuser == OP_RUN |=> !s_tready, "input taken right after a run word")

    // Drop the result channel out of reset
    `LAGE_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind life_automaton_generation_engine lage_checker u_lage_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
